/* rtl/core/cope_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cope_pkg
// shared constants and the cordic angle table for the orbit position unit
// ----------------------------------------------------------------------------
package cope_pkg;

  localparam int ATAN_ENTRIES = 24;

  localparam logic [2:0] REG_ORBIT_RADIUS  = 3'd0;
  localparam logic [2:0] REG_ORBIT_RATE    = 3'd1;
  localparam logic [2:0] REG_START_ANOMALY = 3'd2;
  localparam logic [2:0] REG_NODE_COSINE   = 3'd3;
  localparam logic [2:0] REG_NODE_SINE     = 3'd4;
  localparam logic [2:0] REG_TILT_COSINE   = 3'd5;
  localparam logic [2:0] REG_TILT_SINE     = 3'd6;
  localparam logic [2:0] REG_EARTH_RATE    = 3'd7;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [35:0] POS_MAX = 36'sd134217727;
  localparam logic signed [35:0] POS_MIN = -36'sd134217728;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933405;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335086;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;
      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;
      5'd21: v = 32'd325;
      5'd22: v = 32'd162;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/cope_phase.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cope_phase
// two-stage phase computation: anomaly and earth angle from the time word
// ----------------------------------------------------------------------------
module cope_phase import cope_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  logic [39:0] sim_time,
  input  logic [31:0] orbit_rate,
  input  logic [31:0] earth_rate,
  input  logic [31:0] start_anomaly,
  output logic        out_vld,
  output logic [31:0] anomaly,
  output logic [31:0] earth_ang
);

  logic        vld1;
  logic [55:0] po_lo, pe_lo;
  logic [23:0] po_hi, pe_hi;
  logic [47:0] po_full, pe_full;
  logic [47:0] prod_oh, prod_eh;

  assign prod_oh = 48'(orbit_rate) * 48'(sim_time[39:24]);
  assign prod_eh = 48'(earth_rate) * 48'(sim_time[39:24]);

  always_ff @(posedge clk) begin
    if (en) begin
      po_lo <= 56'(orbit_rate) * 56'(sim_time[23:0]);
      pe_lo <= 56'(earth_rate) * 56'(sim_time[23:0]);
      po_hi <= prod_oh[23:0];
      pe_hi <= prod_eh[23:0];
    end
  end

  assign po_full = po_lo[47:0] + {po_hi, 24'd0};
  assign pe_full = pe_lo[47:0] + {pe_hi, 24'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      anomaly   <= po_full[47:16] + start_anomaly;
      earth_ang <= pe_full[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

endmodule

/* rtl/core/cope_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cope_cordic
// pipelined rotation-mode cordic, one stage per register, binary angle input
// ----------------------------------------------------------------------------
module cope_cordic import cope_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [31:0]        angle,
  output logic               out_vld,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic signed [33:0] xs [0:STAGES];
  logic signed [33:0] ys [0:STAGES];
  logic signed [33:0] zs [0:STAGES];
  logic               flp [0:STAGES];
  logic               vld [0:STAGES];
  logic [31:0]        quad;
  logic [31:0]        am;
  logic signed [33:0] nx, ny;

  assign quad = angle + 32'h4000_0000;
  assign am   = quad[31] ? (angle ^ 32'h8000_0000) : angle;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= CORDIC_GAIN;
      ys[0]  <= '0;
      zs[0]  <= {{2{am[31]}}, am};
      flp[0] <= quad[31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [33:0] dx, dy, da;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign da = signed'({2'b00, atan_turn(5'(i))});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - da;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + da;
        end
        flp[i+1] <= flp[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  assign nx = -xs[STAGES];
  assign ny = -ys[STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= flp[STAGES] ? nx[31:0] : xs[STAGES][31:0];
      sin_o <= flp[STAGES] ? ny[31:0] : ys[STAGES][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[STAGES];
    end
  end

endmodule

/* rtl/core/cope_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cope_frame
// six-stage frame rotation, radius scaling, rounding and saturation
// ----------------------------------------------------------------------------
module cope_frame import cope_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [31:0] cv,
  input  logic signed [31:0] sv,
  input  logic signed [31:0] ce,
  input  logic signed [31:0] se,
  input  logic signed [15:0] co,
  input  logic signed [15:0] so,
  input  logic signed [15:0] ci,
  input  logic signed [15:0] si,
  input  logic [26:0]        radius,
  output logic               out_vld,
  output logic signed [27:0] pos_x,
  output logic signed [27:0] pos_y,
  output logic signed [27:0] pos_z
);

  logic [4:0] vld;

  // stage 1
  logic signed [47:0] p_tt, p_ez;
  logic signed [47:0] pcc, psc;
  logic signed [32:0] tt, ez1;
  logic signed [31:0] ce1, se1;
  assign p_tt = 48'(sv) * 48'(ci);
  assign p_ez = 48'(sv) * 48'(si);

  always_ff @(posedge clk) begin
    if (en) begin
      pcc <= 48'(co) * 48'(cv);
      psc <= 48'(so) * 48'(cv);
      tt  <= p_tt[47:15];
      ez1 <= p_ez[47:15];
      ce1 <= ce;
      se1 <= se;
    end
  end

  // stage 2
  logic signed [49:0] sux, suy;
  logic signed [34:0] ux, uy;
  logic signed [32:0] ez2;
  logic signed [31:0] ce2, se2;
  assign sux = 50'(pcc) - 50'(so) * 50'(tt);
  assign suy = 50'(psc) + 50'(co) * 50'(tt);

  always_ff @(posedge clk) begin
    if (en) begin
      ux  <= sux[49:15];
      uy  <= suy[49:15];
      ez2 <= ez1;
      ce2 <= ce1;
      se2 <= se1;
    end
  end

  // stage 3
  logic signed [66:0] pxc, pys, pyc, pxs;
  logic signed [32:0] ez3;

  always_ff @(posedge clk) begin
    if (en) begin
      pxc <= 67'(ux) * 67'(ce2);
      pys <= 67'(uy) * 67'(se2);
      pyc <= 67'(uy) * 67'(ce2);
      pxs <= 67'(ux) * 67'(se2);
      ez3 <= ez2;
    end
  end

  // stage 4
  logic signed [67:0] sex, sey;
  logic signed [37:0] ex, ey;
  logic signed [32:0] ez4;
  assign sex = 68'(pxc) + 68'(pys);
  assign sey = 68'(pyc) - 68'(pxs);

  always_ff @(posedge clk) begin
    if (en) begin
      ex  <= sex[67:30];
      ey  <= sey[67:30];
      ez4 <= ez3;
    end
  end

  // stage 5
  logic signed [65:0] qx, qy, qz;
  logic signed [27:0] rs;
  assign rs = signed'({1'b0, radius});

  always_ff @(posedge clk) begin
    if (en) begin
      qx <= 66'(rs) * 66'(ex);
      qy <= 66'(rs) * 66'(ey);
      qz <= 66'(rs) * 66'(ez4);
    end
  end

  // stage 6
  function automatic logic signed [27:0] round_sat(input logic signed [65:0] q);
    logic signed [65:0] s;
    logic signed [35:0] v;
    logic signed [27:0] r;
    s = q + 66'sd536870912;
    v = s[65:30];
    if (v > POS_MAX) begin
      r = POS_MAX[27:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[27:0];
    end else begin
      r = v[27:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= round_sat(qx);
      pos_y <= round_sat(qy);
      pos_z <= round_sat(qz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[3:0], in_vld};
      out_vld <= vld[4];
    end
  end

endmodule

/* rtl/core/circular_orbit_position_ecef_unit.sv */
`timescale 1ns / 1ps
// throughput: one word per cycle while the output is not stalled, set by the fully pipelined cordic and frame stages
// a stalled output word holds the whole pipeline in place
// reset: synchronous, clears all valid bits and loads the register reset values
// ----------------------------------------------------------------------------
// circular_orbit_position_ecef_unit
// earth-fixed position of a satellite on a circular inclined orbit
// ----------------------------------------------------------------------------
module circular_orbit_position_ecef_unit import cope_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [39:0]        sim_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [27:0] pos_x,
  output logic signed [27:0] pos_y,
  output logic signed [27:0] pos_z
);

  logic [26:0]        orbit_radius;
  logic [31:0]        orbit_rate;
  logic [31:0]        start_anomaly;
  logic signed [15:0] node_cosine;
  logic signed [15:0] node_sine;
  logic signed [15:0] tilt_cosine;
  logic signed [15:0] tilt_sine;
  logic [31:0]        earth_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      orbit_radius  <= '0;
      orbit_rate    <= '0;
      start_anomaly <= '0;
      node_cosine   <= 16'sd32767;
      node_sine     <= '0;
      tilt_cosine   <= 16'sd32767;
      tilt_sine     <= '0;
      earth_rate    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORBIT_RADIUS:  orbit_radius  <= cfg_data[26:0];
        REG_ORBIT_RATE:    orbit_rate    <= cfg_data;
        REG_START_ANOMALY: start_anomaly <= cfg_data;
        REG_NODE_COSINE:   node_cosine   <= cfg_data[15:0];
        REG_NODE_SINE:     node_sine     <= cfg_data[15:0];
        REG_TILT_COSINE:   tilt_cosine   <= cfg_data[15:0];
        REG_TILT_SINE:     tilt_sine     <= cfg_data[15:0];
        REG_EARTH_RATE:    earth_rate    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic               ph_vld;
  logic [31:0]        anomaly, earth_ang;
  logic               cv_vld, ce_vld;
  logic signed [31:0] cv, sv, ce, se;

  cope_phase u_phase (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_vld        (in_valid),
    .sim_time      (sim_time),
    .orbit_rate    (orbit_rate),
    .earth_rate    (earth_rate),
    .start_anomaly (start_anomaly),
    .out_vld       (ph_vld),
    .anomaly       (anomaly),
    .earth_ang     (earth_ang)
  );

  cope_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_orbit (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (ph_vld),
    .angle   (anomaly),
    .out_vld (cv_vld),
    .cos_o   (cv),
    .sin_o   (sv)
  );

  cope_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_earth (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (ph_vld),
    .angle   (earth_ang),
    .out_vld (ce_vld),
    .cos_o   (ce),
    .sin_o   (se)
  );

  cope_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (cv_vld && ce_vld),
    .cv      (cv),
    .sv      (sv),
    .ce      (ce),
    .se      (se),
    .co      (node_cosine),
    .so      (node_sine),
    .ci      (tilt_cosine),
    .si      (tilt_sine),
    .radius  (orbit_radius),
    .out_vld (out_valid),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .pos_z   (pos_z)
  );

endmodule
